@@ hw/rtl/rpi_pkg.sv @@
// Shared types, register indexes and status codes for the ray-plane block.
package rpi_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned TOL_W   = 31;
    localparam int unsigned DIFF_W  = 33;
    localparam int unsigned PROD_W  = 65;
    localparam int unsigned DOT_W   = 67;
    localparam int unsigned QUOT_W  = 31;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_TOL = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PAR_TOL  = 4'd7;

    localparam logic [1:0] ST_ON_PLANE = 2'd0;
    localparam logic [1:0] ST_POSITIVE = 2'd1;
    localparam logic [1:0] ST_NEGATIVE = 2'd2;
    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_BEHIND   = 2'd2;

    localparam logic [QUOT_W-1:0] DIST_MAX = 31'h7FFF_FFFF;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t vec3_t [3];

    typedef struct packed {
        logic [1:0] status;
        logic       hit_ok;
        logic       sat;
        coord_t     px;
        coord_t     py;
        coord_t     pz;
        coord_t     dx;
        coord_t     dy;
        coord_t     dz;
    } token_t;

    typedef struct packed {
        coord_t          org_x;
        coord_t          org_y;
        coord_t          org_z;
        coord_t          nrm_x;
        coord_t          nrm_y;
        coord_t          nrm_z;
        logic [TOL_W-1:0] side_tol;
        logic [TOL_W-1:0] par_tol;
    } plane_t;

endpackage

@@ hw/rtl/rpi_front.sv @@
// Front pipeline: differences, products, dot sums and classification.
module rpi_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic                            in_op,
    input  rpi_pkg::coord_t                 in_px,
    input  rpi_pkg::coord_t                 in_py,
    input  rpi_pkg::coord_t                 in_pz,
    input  rpi_pkg::coord_t                 in_dx,
    input  rpi_pkg::coord_t                 in_dy,
    input  rpi_pkg::coord_t                 in_dz,
    input  rpi_pkg::plane_t                 plane,
    output logic                            out_valid,
    output rpi_pkg::token_t                 out_tok,
    output logic [rpi_pkg::DOT_W-1:0]       out_den,
    output logic [rpi_pkg::DOT_W-1:0]       out_rem,
    output logic [rpi_pkg::QUOT_W-1:0]      out_nlow
);
    localparam int unsigned DW = rpi_pkg::DOT_W;

    // stage A
    logic                               a_valid_reg;
    logic                               a_op_reg;
    logic signed [rpi_pkg::DIFF_W-1:0]  a_dfx_reg, a_dfy_reg, a_dfz_reg;
    rpi_pkg::coord_t a_px_reg, a_py_reg, a_pz_reg, a_dx_reg, a_dy_reg, a_dz_reg;
    // stage B
    logic                               b_valid_reg;
    logic                               b_op_reg;
    logic signed [rpi_pkg::PROD_W-1:0]  b_kx_reg, b_ky_reg, b_kz_reg;
    logic signed [rpi_pkg::PROD_W-1:0]  b_lx_reg, b_ly_reg, b_lz_reg;
    rpi_pkg::coord_t b_px_reg, b_py_reg, b_pz_reg, b_dx_reg, b_dy_reg, b_dz_reg;
    // stage C
    logic                               c_valid_reg;
    logic                               c_op_reg;
    logic signed [DW-1:0]               c_k_reg, c_l1_reg;
    rpi_pkg::coord_t c_px_reg, c_py_reg, c_pz_reg, c_dx_reg, c_dy_reg, c_dz_reg;
    // stage D
    logic                               d_valid_reg;
    rpi_pkg::token_t                    d_tok_reg;
    logic [DW-1:0]                      d_den_reg, d_rem_reg;
    logic [rpi_pkg::QUOT_W-1:0]         d_nlow_reg;

    logic [DW-1:0]   abs_k, abs_l1, tol_s, tol_p;
    logic            k_zero;
    rpi_pkg::token_t tok_next;

    function automatic logic signed [rpi_pkg::PROD_W-1:0] PROD_SX(
        input logic signed [63:0] v);
        PROD_SX = {v[63], v};
    endfunction

    function automatic logic signed [DW-1:0] DOT_SX(
        input logic signed [rpi_pkg::PROD_W-1:0] v);
        DOT_SX = {{2{v[rpi_pkg::PROD_W-1]}}, v};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (ce) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_op_reg  <= in_op;
            a_dfx_reg <= $signed({in_px[31], in_px}) - $signed({plane.org_x[31], plane.org_x});
            a_dfy_reg <= $signed({in_py[31], in_py}) - $signed({plane.org_y[31], plane.org_y});
            a_dfz_reg <= $signed({in_pz[31], in_pz}) - $signed({plane.org_z[31], plane.org_z});
            a_px_reg <= in_px; a_py_reg <= in_py; a_pz_reg <= in_pz;
            a_dx_reg <= in_dx; a_dy_reg <= in_dy; a_dz_reg <= in_dz;

            b_op_reg <= a_op_reg;
            b_kx_reg <= a_dfx_reg * plane.nrm_x;
            b_ky_reg <= a_dfy_reg * plane.nrm_y;
            b_kz_reg <= a_dfz_reg * plane.nrm_z;
            b_lx_reg <= PROD_SX(a_dx_reg * plane.nrm_x);
            b_ly_reg <= PROD_SX(a_dy_reg * plane.nrm_y);
            b_lz_reg <= PROD_SX(a_dz_reg * plane.nrm_z);
            b_px_reg <= a_px_reg; b_py_reg <= a_py_reg; b_pz_reg <= a_pz_reg;
            b_dx_reg <= a_dx_reg; b_dy_reg <= a_dy_reg; b_dz_reg <= a_dz_reg;

            c_op_reg <= b_op_reg;
            c_k_reg  <= DOT_SX(b_kx_reg) + DOT_SX(b_ky_reg) + DOT_SX(b_kz_reg);
            c_l1_reg <= DOT_SX(b_lx_reg) + DOT_SX(b_ly_reg) + DOT_SX(b_lz_reg);
            c_px_reg <= b_px_reg; c_py_reg <= b_py_reg; c_pz_reg <= b_pz_reg;
            c_dx_reg <= b_dx_reg; c_dy_reg <= b_dy_reg; c_dz_reg <= b_dz_reg;

            d_tok_reg  <= tok_next;
            d_den_reg  <= abs_l1;
            d_rem_reg  <= {15'd0, abs_k[DW-1:15]};
            d_nlow_reg <= {abs_k[14:0], 16'd0};
        end
    end

    always_comb begin
        abs_k  = c_k_reg[DW-1] ? DW'(-c_k_reg) : DW'(c_k_reg);
        abs_l1 = c_l1_reg[DW-1] ? DW'(-c_l1_reg) : DW'(c_l1_reg);
        tol_s  = {20'd0, plane.side_tol, 16'd0};
        tol_p  = {20'd0, plane.par_tol, 16'd0};
        k_zero = (c_k_reg == '0);
        tok_next.px = c_px_reg; tok_next.py = c_py_reg; tok_next.pz = c_pz_reg;
        tok_next.dx = c_dx_reg; tok_next.dy = c_dy_reg; tok_next.dz = c_dz_reg;
        tok_next.hit_ok = 1'b0;
        tok_next.sat = ({abs_l1, 15'd0} <= {15'd0, abs_k});
        if (!c_op_reg) begin
            if (abs_k <= tol_s)
                tok_next.status = rpi_pkg::ST_ON_PLANE;
            else
                tok_next.status = c_k_reg[DW-1] ? rpi_pkg::ST_NEGATIVE : rpi_pkg::ST_POSITIVE;
        end else if (abs_l1 <= tol_p) begin
            tok_next.status = rpi_pkg::ST_PARALLEL;
        end else if (k_zero || (c_k_reg[DW-1] == c_l1_reg[DW-1])) begin
            // l0 = -k, so a hit needs k and l1 of opposite sign
            tok_next.status = rpi_pkg::ST_BEHIND;
        end else begin
            tok_next.status = rpi_pkg::ST_HIT;
            tok_next.hit_ok = 1'b1;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_tok   = d_tok_reg;
    assign out_den   = d_den_reg;
    assign out_rem   = d_rem_reg;
    assign out_nlow  = d_nlow_reg;

endmodule

@@ hw/rtl/rpi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module rpi_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  logic                        in_valid,
    input  rpi_pkg::token_t             in_tok,
    input  logic [rpi_pkg::DOT_W-1:0]   in_den,
    input  logic [rpi_pkg::DOT_W-1:0]   in_rem,
    input  logic [rpi_pkg::QUOT_W-1:0]  in_nlow,
    output logic                        out_valid,
    output rpi_pkg::token_t             out_tok,
    output logic [rpi_pkg::QUOT_W-1:0]  out_quot
);
    localparam int unsigned DW = rpi_pkg::DOT_W;
    localparam int unsigned QW = rpi_pkg::QUOT_W;

    logic                 valid_reg [QW+1];
    rpi_pkg::token_t      tok_reg   [QW+1];
    logic [DW-1:0]        den_reg   [QW+1];
    logic [DW-1:0]        rem_reg   [QW+1];
    logic [QW-1:0]        nlow_reg  [QW+1];
    logic [QW-1:0]        quot_reg  [QW+1];

    always_comb begin
        valid_reg[0] = in_valid;
        tok_reg[0]   = in_tok;
        den_reg[0]   = in_den;
        rem_reg[0]   = in_rem;
        nlow_reg[0]  = in_nlow;
        quot_reg[0]  = '0;
    end

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;
        always_comb begin
            trial = {rem_reg[j], nlow_reg[j][QW-1]};
            ge    = (trial >= {1'b0, den_reg[j]});
            diff  = trial - {1'b0, den_reg[j]};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j+1] <= 1'b0;
            end else if (ce) begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                tok_reg[j+1]  <= tok_reg[j];
                den_reg[j+1]  <= den_reg[j];
                rem_reg[j+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                nlow_reg[j+1] <= {nlow_reg[j][QW-2:0], 1'b0};
                quot_reg[j+1] <= {quot_reg[j][QW-2:0], ge};
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign out_tok   = tok_reg[QW];
    assign out_quot  = quot_reg[QW];

endmodule

@@ hw/rtl/rpi_hit.sv @@
// Hit point stages: direction times distance, offset, floor and saturate.
module rpi_hit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  logic                        in_valid,
    input  rpi_pkg::token_t             in_tok,
    input  logic [rpi_pkg::QUOT_W-1:0]  in_quot,
    output logic                        out_valid,
    output logic [1:0]                  out_status,
    output logic [rpi_pkg::QUOT_W-1:0]  out_dist,
    output rpi_pkg::coord_t             out_hx,
    output rpi_pkg::coord_t             out_hy,
    output rpi_pkg::coord_t             out_hz
);
    localparam int unsigned QW = rpi_pkg::QUOT_W;

    logic [QW-1:0]        s_val;
    logic                 hit_now;
    logic [1:0]           st_now;

    logic                 h_valid_reg;
    logic                 h_hit_reg;
    logic [1:0]           h_status_reg;
    logic [QW-1:0]        h_dist_reg;
    logic signed [62:0]   h_mx_reg, h_my_reg, h_mz_reg;
    rpi_pkg::coord_t      h_px_reg, h_py_reg, h_pz_reg;

    logic                 o_valid_reg;
    logic [1:0]           o_status_reg;
    logic [QW-1:0]        o_dist_reg;
    rpi_pkg::coord_t      o_hx_reg, o_hy_reg, o_hz_reg;

    always_comb begin
        s_val   = in_tok.sat ? rpi_pkg::DIST_MAX : in_quot;
        hit_now = in_tok.hit_ok && (s_val != '0);
        if (in_tok.hit_ok && !hit_now)
            st_now = rpi_pkg::ST_BEHIND;
        else
            st_now = in_tok.status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (ce) begin
            h_valid_reg <= in_valid;
            o_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            h_hit_reg    <= hit_now;
            h_status_reg <= st_now;
            h_dist_reg   <= s_val;
            h_mx_reg     <= in_tok.dx * $signed({1'b0, s_val});
            h_my_reg     <= in_tok.dy * $signed({1'b0, s_val});
            h_mz_reg     <= in_tok.dz * $signed({1'b0, s_val});
            h_px_reg     <= in_tok.px;
            h_py_reg     <= in_tok.py;
            h_pz_reg     <= in_tok.pz;

            o_status_reg <= h_status_reg;
            o_dist_reg   <= h_hit_reg ? h_dist_reg : '0;
            o_hx_reg     <= h_hit_reg ? coord_sat(h_px_reg, h_mx_reg) : '0;
            o_hy_reg     <= h_hit_reg ? coord_sat(h_py_reg, h_my_reg) : '0;
            o_hz_reg     <= h_hit_reg ? coord_sat(h_pz_reg, h_mz_reg) : '0;
        end
    end

    function automatic rpi_pkg::coord_t coord_sat(input rpi_pkg::coord_t p,
                                                   input logic signed [62:0] m);
        logic signed [63:0] v;
        logic signed [47:0] q;
        v = $signed({{16{p[31]}}, p, 16'd0}) + $signed({m[62], m});
        q = v[63:16];
        if (q > 48'sh0000_7FFF_FFFF)
            coord_sat = 32'sh7FFF_FFFF;
        else if (q < -48'sh0000_8000_0000)
            coord_sat = 32'sh8000_0000;
        else
            coord_sat = q[31:0];
    endfunction

    assign out_valid  = o_valid_reg;
    assign out_status = o_status_reg;
    assign out_dist   = o_dist_reg;
    assign out_hx     = o_hx_reg;
    assign out_hy     = o_hy_reg;
    assign out_hz     = o_hz_reg;

endmodule

@@ hw/rtl/plane_side_and_ray_intersection.sv @@
// Top level: plane registers, pipeline control and stream ports.
//
// Usage:
//   The plane (origin, normal, two tolerances) is loaded through the
//   cfg_we/cfg_addr/cfg_wdata port, index 0..7, while no item is in flight.
//   Each input item carries op in s_tuser and the point and direction in
//   s_tdata; op 0 classifies the point, op 1 intersects the ray.
//   Each item yields one result item: status in m_tuser, distance and hit
//   point in m_tdata.
// Timing:
//   The pipeline has four stages for differences, products, dot sums and
//   classification, 31 stages of the one-bit-per-stage divider, and two
//   stages for the hit point. One item is accepted every cycle unless stalled.
// Reset:
//   aresetn low clears all valid bits and loads the plane registers with
//   origin 0, normal (0, 0, 1.0) and zero tolerances.
// Stall:
//   When m_tready is low while a result waits, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
module plane_side_and_ray_intersection (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [rpi_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [31:0]                     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_x, point_y, point_z, dir_x, dir_y, dir_z
    input  logic [191:0]                    s_tdata,
    // op
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // distance, hit_x, hit_y, hit_z, one pad bit
    output logic [127:0]                    m_tdata,
    // status
    output logic [1:0]                      m_tuser
);
    rpi_pkg::plane_t plane_reg;
    logic            ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg.org_x    <= '0;
            plane_reg.org_y    <= '0;
            plane_reg.org_z    <= '0;
            plane_reg.nrm_x    <= '0;
            plane_reg.nrm_y    <= '0;
            plane_reg.nrm_z    <= 32'sd65536;
            plane_reg.side_tol <= '0;
            plane_reg.par_tol  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                rpi_pkg::REG_ORIGIN_X: plane_reg.org_x    <= cfg_wdata;
                rpi_pkg::REG_ORIGIN_Y: plane_reg.org_y    <= cfg_wdata;
                rpi_pkg::REG_ORIGIN_Z: plane_reg.org_z    <= cfg_wdata;
                rpi_pkg::REG_NORMAL_X: plane_reg.nrm_x    <= cfg_wdata;
                rpi_pkg::REG_NORMAL_Y: plane_reg.nrm_y    <= cfg_wdata;
                rpi_pkg::REG_NORMAL_Z: plane_reg.nrm_z    <= cfg_wdata;
                rpi_pkg::REG_SIDE_TOL: plane_reg.side_tol <= cfg_wdata[30:0];
                rpi_pkg::REG_PAR_TOL:  plane_reg.par_tol  <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    logic                       f_valid;
    rpi_pkg::token_t            f_tok;
    logic [rpi_pkg::DOT_W-1:0]  f_den, f_rem;
    logic [rpi_pkg::QUOT_W-1:0] f_nlow;
    logic                       q_valid;
    rpi_pkg::token_t            q_tok;
    logic [rpi_pkg::QUOT_W-1:0] q_quot;
    logic [rpi_pkg::QUOT_W-1:0] o_dist;
    rpi_pkg::coord_t            o_hx, o_hy, o_hz;

    rpi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_px    (s_tdata[31:0]),
        .in_py    (s_tdata[63:32]),
        .in_pz    (s_tdata[95:64]),
        .in_dx    (s_tdata[127:96]),
        .in_dy    (s_tdata[159:128]),
        .in_dz    (s_tdata[191:160]),
        .plane    (plane_reg),
        .out_valid(f_valid),
        .out_tok  (f_tok),
        .out_den  (f_den),
        .out_rem  (f_rem),
        .out_nlow (f_nlow)
    );

    rpi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (f_valid),
        .in_tok   (f_tok),
        .in_den   (f_den),
        .in_rem   (f_rem),
        .in_nlow  (f_nlow),
        .out_valid(q_valid),
        .out_tok  (q_tok),
        .out_quot (q_quot)
    );

    rpi_hit u_hit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (q_valid),
        .in_tok    (q_tok),
        .in_quot   (q_quot),
        .out_valid (m_tvalid),
        .out_status(m_tuser),
        .out_dist  (o_dist),
        .out_hx    (o_hx),
        .out_hy    (o_hy),
        .out_hz    (o_hz)
    );

    assign m_tdata = {1'b0, o_hz, o_hy, o_hx, o_dist};

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("invalid status code");
    a_dist_only_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[30:0] != 31'd0) |-> m_tuser == rpi_pkg::ST_HIT)
        else $error("distance on non-hit");
    a_ready_only_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("ready dropped without stall");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result lost under stall");

endmodule

@@ dv/tb_plane_side_and_ray_intersection.sv @@
// Testbench for plane_side_and_ray_intersection: side test and ray hit, checked by prediction.
`timescale 1ns / 100ps

module tb_plane_side_and_ray_intersection;

    localparam int LATENCY    = 37;
    localparam int STALL_STOP = 4000;

    typedef struct {
        logic [1:0]                 status;
        logic [rpi_pkg::QUOT_W-1:0] distance;
        rpi_pkg::coord_t            hit_x;
        rpi_pkg::coord_t            hit_y;
        rpi_pkg::coord_t            hit_z;
    } answer_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [rpi_pkg::CFG_IDX_W-1:0] cfg_addr;
    logic [31:0]                   cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [191:0]                  s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [127:0]                  m_tdata;
    logic [1:0]                    m_tuser;

    plane_side_and_ray_intersection u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Plane copy kept alongside the DUT registers
    rpi_pkg::coord_t            pl_org [3];
    rpi_pkg::coord_t            pl_nrm [3];
    logic [rpi_pkg::TOL_W-1:0]  pl_side_tol;
    logic [rpi_pkg::TOL_W-1:0]  pl_par_tol;

    answer_t pending_answers [$];
    int      n_errors;
    int      quiet_cycles;
    bit      no_idle;
    int      stall_left;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic signed [127:0] mag(logic signed [127:0] x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic rpi_pkg::coord_t sat32(logic signed [127:0] x);
        if (x > 128'sd2147483647) return 32'sh7FFF_FFFF;
        if (x < -128'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic answer_t plane_query(bit op, rpi_pkg::coord_t p [3],
                                            rpi_pkg::coord_t d [3]);
        logic signed [127:0] k, l0, l1, a, b, num, s, v, pw, dw, tol;
        rpi_pkg::coord_t hc [3];
        answer_t r;
        r = '{status: rpi_pkg::ST_ON_PLANE, distance: '0, hit_x: '0, hit_y: '0, hit_z: '0};
        k = 0; l0 = 0; l1 = 0;
        for (int i = 0; i < 3; i++) begin
            k  += (128'(p[i]) - 128'(pl_org[i])) * 128'(pl_nrm[i]);
            l0 += (128'(pl_org[i]) - 128'(p[i])) * 128'(pl_nrm[i]);
            l1 += 128'(d[i]) * 128'(pl_nrm[i]);
        end
        if (!op) begin
            tol = 128'(pl_side_tol) <<< 16;
            if (mag(k) <= tol) r.status = rpi_pkg::ST_ON_PLANE;
            else r.status = (k < 0) ? rpi_pkg::ST_NEGATIVE : rpi_pkg::ST_POSITIVE;
            return r;
        end
        tol = 128'(pl_par_tol) <<< 16;
        if (mag(l1) <= tol) begin
            r.status = rpi_pkg::ST_PARALLEL;
            return r;
        end
        if (l0 == 0 || ((l0 < 0) != (l1 < 0))) begin
            r.status = rpi_pkg::ST_BEHIND;
            return r;
        end
        a = mag(l0);
        b = mag(l1);
        num = a <<< 16;
        if ((b <<< 31) <= num) s = 128'(rpi_pkg::DIST_MAX);
        else s = num / b;
        if (s == 0) begin
            r.status = rpi_pkg::ST_BEHIND;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            pw = 128'(p[i]);
            dw = 128'(d[i]);
            v = (pw <<< 16) + dw * s;
            hc[i] = sat32(v >>> 16);
        end
        r.status   = rpi_pkg::ST_HIT;
        r.distance = s[rpi_pkg::QUOT_W-1:0];
        r.hit_x    = hc[0];
        r.hit_y    = hc[1];
        r.hit_z    = hc[2];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic rpi_pkg::coord_t any_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: return $signed($urandom_range(0, 511)) - 256;
            default: return $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
        endcase
    endfunction

    // Sender: item stays on the bus until accepted
    task automatic send_item(bit op, rpi_pkg::coord_t p [3], rpi_pkg::coord_t d [3]);
        int g;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {d[2], d[1], d[0], p[2], p[1], p[0]};
        do @(posedge aclk); while (!s_tready);
        pending_answers.push_back(plane_query(op, p, d));
        g = pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic [rpi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            rpi_pkg::REG_ORIGIN_X: pl_org[0] = val;
            rpi_pkg::REG_ORIGIN_Y: pl_org[1] = val;
            rpi_pkg::REG_ORIGIN_Z: pl_org[2] = val;
            rpi_pkg::REG_NORMAL_X: pl_nrm[0] = val;
            rpi_pkg::REG_NORMAL_Y: pl_nrm[1] = val;
            rpi_pkg::REG_NORMAL_Z: pl_nrm[2] = val;
            rpi_pkg::REG_SIDE_TOL: pl_side_tol = val[rpi_pkg::TOL_W-1:0];
            rpi_pkg::REG_PAR_TOL:  pl_par_tol  = val[rpi_pkg::TOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_plane(rpi_pkg::coord_t o [3], rpi_pkg::coord_t n [3],
                              logic [31:0] st, logic [31:0] pt);
        write_reg(rpi_pkg::REG_ORIGIN_X, o[0]);
        write_reg(rpi_pkg::REG_ORIGIN_Y, o[1]);
        write_reg(rpi_pkg::REG_ORIGIN_Z, o[2]);
        write_reg(rpi_pkg::REG_NORMAL_X, n[0]);
        write_reg(rpi_pkg::REG_NORMAL_Y, n[1]);
        write_reg(rpi_pkg::REG_NORMAL_Z, n[2]);
        write_reg(rpi_pkg::REG_SIDE_TOL, st);
        write_reg(rpi_pkg::REG_PAR_TOL, pt);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (LATENCY + 3) @(posedge aclk);
    endtask

    task automatic test_side_classify();
        rpi_pkg::coord_t p [3];
        rpi_pkg::coord_t d [3];
        d = '{0, 0, 0};
        p = '{0, 0, 0};                         send_item(1'b0, p, d);
        p = '{5, -7, 32'sh0001_0000};           send_item(1'b0, p, d);
        p = '{0, 0, -32'sh0000_0001};           send_item(1'b0, p, d);
        p = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
        d = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        send_item(1'b0, p, d);
        p = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        send_item(1'b0, p, d);
        drain();
    endtask

    task automatic test_ray_cases();
        rpi_pkg::coord_t p [3];
        rpi_pkg::coord_t d [3];
        // plain hit
        p = '{32'sh0002_0000, 0, -32'sh000A_0000}; d = '{0, 0, 32'sh0001_0000};
        send_item(1'b1, p, d);
        // parallel, exactly zero
        d = '{32'sh0001_0000, 32'sh0003_0000, 0};  send_item(1'b1, p, d);
        // behind, opposite signs
        d = '{0, 0, -32'sh0001_0000};              send_item(1'b1, p, d);
        // start on plane: l0 zero
        p = '{7, 9, 0}; d = '{0, 0, 32'sh0001_0000}; send_item(1'b1, p, d);
        // quotient truncates to zero
        p = '{0, 0, -1}; d = '{0, 0, 32'sh7FFF_FFFF}; send_item(1'b1, p, d);
        // distance clamps, hit coordinates saturate both ways
        p = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000};
        d = '{32'sh7FFF_FFFF, 32'sh8000_0000, 1};
        send_item(1'b1, p, d);
        p = '{0, 0, 32'sh8000_0000}; d = '{-1, 32'sh0000_8000, 1};
        send_item(1'b1, p, d);
        drain();
    endtask

    task automatic test_plane_extremes();
        rpi_pkg::coord_t o [3];
        rpi_pkg::coord_t n [3];
        rpi_pkg::coord_t p [3];
        rpi_pkg::coord_t d [3];
        o = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
        n = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        load_plane(o, n, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // indexes past the last register must be ignored
        write_reg(rpi_pkg::CFG_IDX_W'(8), 32'h1234_5678);
        write_reg(rpi_pkg::CFG_IDX_W'(15), 32'hFFFF_FFFF);
        cfg_we <= 1'b0;
        p = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        d = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        send_item(1'b0, p, d);
        send_item(1'b1, p, d);
        p = '{0, 0, 0};
        send_item(1'b0, p, d);
        drain();
        load_plane(o, n, 32'h0, 32'h0);
        p = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        d = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
        send_item(1'b0, p, d);
        send_item(1'b1, p, d);
        d = '{1, 1, 1};
        send_item(1'b1, p, d);
        drain();
    endtask

    task automatic test_random_planes(int n_sets, int per_set);
        rpi_pkg::coord_t o [3];
        rpi_pkg::coord_t n [3];
        rpi_pkg::coord_t p [3];
        rpi_pkg::coord_t d [3];
        logic [31:0] st, pt;
        for (int k = 0; k < n_sets; k++) begin
            no_idle = (k % 4 == 3);
            for (int i = 0; i < 3; i++) begin
                o[i] = ($urandom_range(0, 3) == 0) ? any_coord()
                       : $signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
                n[i] = ($urandom_range(0, 3) == 0) ? any_coord()
                       : $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            end
            case ($urandom_range(0, 3))
                0: begin st = 0;              pt = 0;              end
                1: begin st = $urandom;       pt = $urandom;       end
                default: begin
                    st = $urandom_range(0, 32'h4_0000);
                    pt = $urandom_range(0, 32'h1_0000);
                end
            endcase
            load_plane(o, n, st, pt);
            for (int j = 0; j < per_set; j++) begin
                for (int i = 0; i < 3; i++) begin
                    p[i] = any_coord();
                    d[i] = ($urandom_range(0, 1) == 0)
                           ? $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000
                           : any_coord();
                end
                // aim some rays at the origin so hits are common
                if ($urandom_range(0, 2) == 0)
                    for (int i = 0; i < 3; i++) d[i] = (o[i] - p[i]) >>> $urandom_range(4, 12);
                send_item(1'($urandom_range(0, 1)), p, d);
            end
            drain();
        end
        no_idle = 1'b0;
    endtask

    // Result checker
    always @(posedge aclk) begin
        answer_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                $error("result item with nothing expected");
                n_errors++;
            end else begin
                e = pending_answers.pop_front();
                if (m_tuser !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_tuser);
                    n_errors++;
                end
                if (m_tdata[30:0] !== e.distance) begin
                    $error("distance: expected %h, got %h", e.distance, m_tdata[30:0]);
                    n_errors++;
                end
                if (m_tdata[62:31] !== e.hit_x) begin
                    $error("hit_x: expected %h, got %h", e.hit_x, m_tdata[62:31]);
                    n_errors++;
                end
                if (m_tdata[94:63] !== e.hit_y) begin
                    $error("hit_y: expected %h, got %h", e.hit_y, m_tdata[94:63]);
                    n_errors++;
                end
                if (m_tdata[126:95] !== e.hit_z) begin
                    $error("hit_z: expected %h, got %h", e.hit_z, m_tdata[126:95]);
                    n_errors++;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            stall_left <= pick_gap();
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_STOP) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        n_errors    = 0;
        quiet_cycles = 0;
        stall_left  = 0;
        no_idle     = 1'b0;
        pl_org      = '{0, 0, 0};
        pl_nrm      = '{0, 0, 32'sh0001_0000};
        pl_side_tol = '0;
        pl_par_tol  = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_side_classify();
        test_ray_cases();
        test_plane_extremes();
        test_random_planes(10, 125);

        drain();
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
